[rtl/hrv_pkg.sv]
// shared types, byte codes and match patterns for the http request header validator
// no dependencies; used by hrv_front, hrv_back and the top level
package hrv_pkg;

	localparam int unsigned RES_LEN_W = 11;
	localparam int unsigned TDATA_IN_W = 8;
	localparam int unsigned TDATA_OUT_W = 24;

	// queue between front and back, power of two deep
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = $clog2(QDEPTH);
	localparam int unsigned QCW = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam logic [3:0] GET_LEN = 4'd3;
	localparam logic [3:0] VER_LEN = 4'd8;
	localparam logic [3:0] HOST_LEN = 4'd4;

	localparam logic [2:0] FC_NONE = 3'd0;
	localparam logic [2:0] FC_METHOD = 3'd1;
	localparam logic [2:0] FC_VERSION = 3'd2;
	localparam logic [2:0] FC_NO_COLON = 3'd3;
	localparam logic [2:0] FC_KEY_SPACE = 3'd4;
	localparam logic [2:0] FC_VALUE_SPACES = 3'd5;
	localparam logic [2:0] FC_NO_HOST = 3'd6;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_SPACE,
		CLS_CR,
		CLS_LF,
		CLS_COLON,
		CLS_SLASH
	} byte_cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
		byte_cls_t cls;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} q_head_t;

	// msb first: host_found sits highest, request_ok at bit 0
	typedef struct packed {
		logic host_found;
		logic [RES_LEN_W-1:0] path_length;
		logic path_is_root;
		logic [2:0] fail_cause;
		logic request_ok;
	} result_t;

	function automatic logic [7:0] pat_get(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = 8'h47; // G
			4'd1: c = 8'h45; // E
			4'd2: c = 8'h54; // T
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pat_ver(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = 8'h48; // H
			4'd1: c = 8'h54; // T
			4'd2: c = 8'h54; // T
			4'd3: c = 8'h50; // P
			4'd4: c = 8'h2f; // /
			4'd5: c = 8'h31; // 1
			4'd6: c = 8'h2e; // .
			4'd7: c = 8'h31; // 1
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pat_host(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = 8'h48; // H
			4'd1: c = 8'h6f; // o
			4'd2: c = 8'h73; // s
			4'd3: c = 8'h74; // t
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/hrv_front.sv]
// front end: accepts header bytes, tags each with its byte class, queues them
// depends on hrv_pkg
module hrv_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] in_byte,
	input  logic in_last,
	output hrv_pkg::q_head_t head,
	input  logic pop
);

	hrv_pkg::item_t q_mem_q [hrv_pkg::QDEPTH];
	logic [hrv_pkg::QAW-1:0] wr_ptr_q;
	logic [hrv_pkg::QAW-1:0] rd_ptr_q;
	logic [hrv_pkg::QCW-1:0] count_q;
	hrv_pkg::byte_cls_t cls;
	logic push;

	always_comb begin
		case (in_byte)
			hrv_pkg::CH_SPACE: cls = hrv_pkg::CLS_SPACE;
			hrv_pkg::CH_CR:    cls = hrv_pkg::CLS_CR;
			hrv_pkg::CH_LF:    cls = hrv_pkg::CLS_LF;
			hrv_pkg::CH_COLON: cls = hrv_pkg::CLS_COLON;
			hrv_pkg::CH_SLASH: cls = hrv_pkg::CLS_SLASH;
			default:           cls = hrv_pkg::CLS_OTHER;
		endcase
	end

	assign in_ready = (count_q != hrv_pkg::QCW'(hrv_pkg::QDEPTH));
	assign push = in_valid && in_ready;

	assign head.valid = (count_q != '0);
	assign head.item = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{data_byte: in_byte, last_byte: in_last, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a pushed word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hrv_pkg::QCW'(hrv_pkg::QDEPTH))
		else $error("queue count above depth");

endmodule

[rtl/hrv_back.sv]
// back end: request header state machine and the result register
// depends on hrv_pkg; takes classified words from the hrv_front queue
module hrv_back #(
	parameter int unsigned LENGTH_LIMIT = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  hrv_pkg::q_head_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output hrv_pkg::result_t out_result
);

	localparam int unsigned PCW = $clog2(LENGTH_LIMIT + 1);
	localparam logic [PCW-1:0] LIMIT_C = PCW'(LENGTH_LIMIT);

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_PATH,
		PH_VERSION,
		PH_KEY,
		PH_VALUE,
		PH_FAILED
	} phase_t;

	typedef struct packed {
		logic brk;
		logic [3:0] pos;
	} match_t;

	phase_t phase_q, phase_n;
	match_t match_q, match_n;
	logic crp_q, crp_n;
	logic [1:0] lsc_q, lsc_n;
	logic txt_q, txt_n;
	logic host_q, host_n;
	logic [2:0] code_q, code_n;
	logic [PCW-1:0] pcnt_q, pcnt_n;
	logic slash_q, slash_n;
	logic out_valid_q;
	hrv_pkg::result_t out_result_q, res_n;
	logic [7:0] b;
	hrv_pkg::byte_cls_t c;
	logic fin;

	function automatic match_t feed(input match_t m, input logic [7:0] bt,
			input logic [7:0] pc, input logic [3:0] n);
		match_t r;
		r = m;
		if (!m.brk && m.pos < n && bt == pc) begin
			r.pos = m.pos + 4'd1;
		end else begin
			r.brk = 1'b1;
		end
		return r;
	endfunction

	assign b = head.item.data_byte;
	assign c = head.item.cls;
	// a final byte needs the result register free
	assign pop = head.valid && (!head.item.last_byte || !out_valid_q || out_ready);
	assign fin = pop && head.item.last_byte;

	always_comb begin
		phase_n = phase_q;
		match_n = match_q;
		crp_n = crp_q;
		lsc_n = lsc_q;
		txt_n = txt_q;
		host_n = host_q;
		code_n = code_q;
		pcnt_n = pcnt_q;
		slash_n = slash_q;
		res_n = out_result_q;

		if (pop) begin
			case (phase_n)
				PH_METHOD: begin
					if (c == hrv_pkg::CLS_SPACE) begin
						if (!match_n.brk && match_n.pos == hrv_pkg::GET_LEN) begin
							phase_n = PH_PATH;
							match_n = '0;
						end else begin
							code_n = hrv_pkg::FC_METHOD;
							phase_n = PH_FAILED;
						end
					end else begin
						match_n = feed(match_n, b, hrv_pkg::pat_get(match_n.pos),
							hrv_pkg::GET_LEN);
					end
				end
				PH_PATH: begin
					if (c == hrv_pkg::CLS_SPACE) begin
						phase_n = PH_VERSION;
						match_n = '0;
					end else begin
						slash_n = (pcnt_n == '0) && (c == hrv_pkg::CLS_SLASH);
						if (pcnt_n < LIMIT_C) begin
							pcnt_n = pcnt_n + 1'b1;
						end
					end
				end
				PH_VERSION: begin
					if (crp_n && c == hrv_pkg::CLS_LF) begin
						crp_n = 1'b0;
						if (!match_n.brk && match_n.pos == hrv_pkg::VER_LEN) begin
							phase_n = PH_KEY;
							match_n = '0;
							lsc_n = '0;
						end else begin
							code_n = hrv_pkg::FC_VERSION;
							phase_n = PH_FAILED;
						end
					end else begin
						// lone cr is version text
						if (crp_n) begin
							match_n = feed(match_n, hrv_pkg::CH_CR,
								hrv_pkg::pat_ver(match_n.pos), hrv_pkg::VER_LEN);
						end
						crp_n = (c == hrv_pkg::CLS_CR);
						if (c != hrv_pkg::CLS_CR) begin
							match_n = feed(match_n, b, hrv_pkg::pat_ver(match_n.pos),
								hrv_pkg::VER_LEN);
						end
					end
				end
				PH_KEY: begin
					if (c == hrv_pkg::CLS_COLON) begin
						if (lsc_n != '0) begin
							code_n = hrv_pkg::FC_KEY_SPACE;
							phase_n = PH_FAILED;
						end else begin
							phase_n = PH_VALUE;
							lsc_n = '0;
							txt_n = 1'b0;
							crp_n = 1'b0;
						end
					end else begin
						// in a key, lsc only flags that a space was seen
						if (c == hrv_pkg::CLS_SPACE) begin
							lsc_n = 2'd1;
						end
						match_n = feed(match_n, b, hrv_pkg::pat_host(match_n.pos),
							hrv_pkg::HOST_LEN);
					end
				end
				PH_VALUE: begin
					if (crp_n && c == hrv_pkg::CLS_LF) begin
						crp_n = 1'b0;
						if (!txt_n) begin
							code_n = hrv_pkg::FC_VALUE_SPACES;
							phase_n = PH_FAILED;
						end else begin
							if (!match_n.brk && match_n.pos == hrv_pkg::HOST_LEN) begin
								host_n = 1'b1;
							end
							phase_n = PH_KEY;
							match_n = '0;
							lsc_n = '0;
							txt_n = 1'b0;
						end
					end else begin
						// lone cr counts as value text
						if (crp_n) begin
							txt_n = 1'b1;
						end
						crp_n = (c == hrv_pkg::CLS_CR);
						if (c != hrv_pkg::CLS_CR && !txt_n) begin
							if (c == hrv_pkg::CLS_SPACE) begin
								lsc_n = lsc_n + 2'd1;
								if (lsc_n >= 2'd2) begin
									code_n = hrv_pkg::FC_VALUE_SPACES;
									phase_n = PH_FAILED;
								end
							end else begin
								txt_n = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (fin) begin
			case (phase_n)
				PH_METHOD: code_n = hrv_pkg::FC_METHOD;
				PH_PATH, PH_VERSION: code_n = hrv_pkg::FC_VERSION;
				PH_KEY: begin
					if (match_n.pos != '0 || match_n.brk) begin
						code_n = hrv_pkg::FC_NO_COLON;
					end
				end
				PH_VALUE: begin
					if (crp_n) begin
						txt_n = 1'b1;
					end
					if (!txt_n) begin
						code_n = hrv_pkg::FC_VALUE_SPACES;
					end else if (!match_n.brk && match_n.pos == hrv_pkg::HOST_LEN) begin
						host_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (code_n == hrv_pkg::FC_NONE && !host_n) begin
				code_n = hrv_pkg::FC_NO_HOST;
			end

			res_n.request_ok = (code_n == hrv_pkg::FC_NONE);
			res_n.fail_cause = code_n;
			res_n.path_is_root = slash_n && (pcnt_n == PCW'(1));
			res_n.path_length = hrv_pkg::RES_LEN_W'(pcnt_n);
			res_n.host_found = host_n;

			// ready for the next request
			phase_n = PH_METHOD;
			match_n = '0;
			crp_n = 1'b0;
			lsc_n = '0;
			txt_n = 1'b0;
			host_n = 1'b0;
			code_n = hrv_pkg::FC_NONE;
			pcnt_n = '0;
			slash_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			match_q <= '0;
			crp_q <= 1'b0;
			lsc_q <= '0;
			txt_q <= 1'b0;
			host_q <= 1'b0;
			code_q <= hrv_pkg::FC_NONE;
			pcnt_q <= '0;
			slash_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_result_q <= '0;
		end else begin
			phase_q <= phase_n;
			match_q <= match_n;
			crp_q <= crp_n;
			lsc_q <= lsc_n;
			txt_q <= txt_n;
			host_q <= host_n;
			code_q <= code_n;
			pcnt_q <= pcnt_n;
			slash_q <= slash_n;
			out_result_q <= res_n;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_result = out_result_q;

	a_failed_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAILED |-> code_q != hrv_pkg::FC_NONE)
		else $error("failed phase without a failure code");

	a_live_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY || phase_q == PH_VALUE) |-> code_q == hrv_pkg::FC_NONE)
		else $error("failure code set while still parsing headers");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> phase_q == PH_METHOD && pcnt_q == '0 && !host_q && out_valid_q)
		else $error("state not cleared after a final byte");

endmodule

[rtl/http_request_header_validator_top.sv]
// top level of the http request header validator
// depends on hrv_pkg, hrv_front and hrv_back
//
// usage
//   input stream: one request header byte per word on s_axis_tdata, s_axis_tlast
//   marks the final byte of a request. output stream: one verdict word per
//   request, sent after its final byte.
//   a final byte is first written into the queue, then popped by the back end,
//   which registers its verdict word in the output register.
//   throughput: one byte per cycle sustained; the byte state machine in the
//   back end consumes one queued word each cycle, and a final byte waits only
//   while the previous verdict is still held in the output register.
//   stall: when m_axis_tready is low the verdict holds, the back end keeps
//   taking non-final bytes, and the four-word queue in front absorbs the rest;
//   s_axis_tready drops only once that queue is full.
//   reset: arst_n low empties the queue, drops m_axis_tvalid and puts the
//   parser back at the start of a request (method phase).
//   verdict fields report the path length and root flag as seen up to the
//   first failure; the path counter saturates at LENGTH_LIMIT.
module http_request_header_validator_top #(
	parameter int unsigned LENGTH_LIMIT = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [7:0] data_byte
	input  logic [hrv_pkg::TDATA_IN_W-1:0] s_axis_tdata,
	// last_byte
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [0] request_ok, [3:1] fail_cause, [4] path_is_root, [15:5] path_length,
	// [16] host_found, [23:17] zero
	output logic [hrv_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

	hrv_pkg::q_head_t head;
	hrv_pkg::result_t result;
	logic pop;

	// front: classify each byte and queue it
	hrv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.head     (head),
		.pop      (pop)
	);

	// back: request parser plus verdict register
	hrv_back #(
		.LENGTH_LIMIT (LENGTH_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	// verdict struct is already packed lowest field at bit 0
	assign m_axis_tdata = hrv_pkg::TDATA_OUT_W'(result);

endmodule
